/* design/csma_ca_mac_controller_macros.svh */
// ---------------------------------------------------------------------------
// CSMA-CA MAC controller assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CSMA_CA_MAC_CONTROLLER_MACROS_SVH
`define CSMA_CA_MAC_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define CSMA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define CSMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CSMA_ASSERT(label, clk, rst_n, prop)
`define CSMA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/csma_pkg.sv */
// ---------------------------------------------------------------------------
// CSMA-CA MAC controller package
// Shared types, event codes and command codes.
// ---------------------------------------------------------------------------
package csma_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BACKOFF  = 3'd1,
    ST_CCA      = 3'd2,
    ST_TXFRAME  = 3'd3,
    ST_WAITACK  = 3'd4,
    ST_WAITSIFS = 3'd5,
    ST_TXACK    = 3'd6
  } mac_state_e;

  localparam logic [3:0] EV_SEND    = 4'd0;
  localparam logic [3:0] EV_BACKOFF = 4'd1;
  localparam logic [3:0] EV_CCA     = 4'd2;
  localparam logic [3:0] EV_SIFS    = 4'd3;
  localparam logic [3:0] EV_ACKTO   = 4'd4;
  localparam logic [3:0] EV_TXDONE  = 4'd5;
  localparam logic [3:0] EV_RXDATA  = 4'd6;
  localparam logic [3:0] EV_RXDUP   = 4'd7;
  localparam logic [3:0] EV_RXBCAST = 4'd8;
  localparam logic [3:0] EV_RXACK   = 4'd9;

  localparam logic [1:0] RADIO_NONE = 2'd0;
  localparam logic [1:0] RADIO_RX   = 2'd1;
  localparam logic [1:0] RADIO_TX   = 2'd2;

  localparam logic [2:0] TSTART_NONE = 3'd0;
  localparam logic [2:0] TSTART_BO   = 3'd1;
  localparam logic [2:0] TSTART_CCA  = 3'd2;
  localparam logic [2:0] TSTART_SIFS = 3'd3;
  localparam logic [2:0] TSTART_ACK  = 3'd4;

  localparam logic [1:0] TCANCEL_NONE = 2'd0;
  localparam logic [1:0] TCANCEL_BO   = 2'd1;
  localparam logic [1:0] TCANCEL_CCA  = 2'd2;
  localparam logic [1:0] TCANCEL_ACK  = 2'd3;

  localparam logic [1:0] TX_NONE  = 2'd0;
  localparam logic [1:0] TX_FRAME = 2'd1;
  localparam logic [1:0] TX_ACK   = 2'd2;

  localparam logic [1:0] DROP_NONE  = 2'd0;
  localparam logic [1:0] DROP_FULL  = 2'd1;
  localparam logic [1:0] DROP_BUSY  = 2'd2;
  localparam logic [1:0] DROP_RETRY = 2'd3;

  localparam logic [2:0] CFG_USE_ACKS  = 3'd0;
  localparam logic [2:0] CFG_QLIMIT    = 3'd1;
  localparam logic [2:0] CFG_MAX_BUSY  = 3'd2;
  localparam logic [2:0] CFG_MAX_RETRY = 3'd3;
  localparam logic [2:0] CFG_BO_MODE   = 3'd4;
  localparam logic [2:0] CFG_MIN_EXP   = 3'd5;
  localparam logic [2:0] CFG_MAX_EXP   = 3'd6;
  localparam logic [2:0] CFG_CW        = 3'd7;

  localparam logic [1:0] BO_LINEAR = 2'd1;
  localparam logic [1:0] BO_EXP    = 2'd2;

  localparam logic [47:0] ADDR_BCAST = 48'hFFFF_FFFF_FFFF;

  // Classified event from the front end
  typedef struct packed {
    logic [3:0]  kind;
    logic [47:0] dest_address;
    logic [47:0] ack_source;
    logic        channel_idle;
  } event_t;

  typedef struct packed {
    logic [1:0]  radio_mode;
    logic [2:0]  timer_start;
    logic [1:0]  timer_cancel;
    logic [1:0]  transmit;
    logic        deliver_up;
    logic [1:0]  drop_cause;
    logic        window_low;
    logic [14:0] window_high;
    logic [2:0]  mac_state;
    logic [3:0]  queue_count;
  } result_t;

  typedef struct packed {
    logic       use_acks;
    logic [3:0] queue_limit;
    logic [3:0] max_busy_backoffs;
    logic [3:0] max_retries;
    logic [1:0] backoff_mode;
    logic [3:0] min_exponent;
    logic [3:0] max_exponent;
    logic [7:0] contention_window;
  } cfg_t;

endpackage

/* design/csma_evt_fifo.sv */
// ---------------------------------------------------------------------------
// CSMA-CA event queue
// Two-entry queue that decouples the event front end from the MAC engine.
// ---------------------------------------------------------------------------
module csma_evt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csma_pkg::event_t  push_data_i,
  output logic              full_o,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output csma_pkg::event_t  pop_data_o
);

  csma_pkg::event_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1;
    rd_ptr_d = rd_ptr_q + 1'b1;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_d;
      if (pop_i) rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/csma_engine.sv */
// ---------------------------------------------------------------------------
// CSMA-CA MAC engine
// Applies an event per cycle, unless its result stalls, to FSM and tx queue.
// ---------------------------------------------------------------------------
module csma_engine #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csma_pkg::cfg_t    cfg_i,
  input  logic              ev_valid_i,
  input  csma_pkg::event_t  ev_i,
  output logic              ev_ready_o,
  output logic              res_valid_o,
  output csma_pkg::result_t res_o,
  input  logic              res_ready_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [47:0] store_q [QUEUE_DEPTH];
  csma_pkg::mac_state_e state_q, state_d;
  logic [PtrW-1:0] head_q, head_d, tail_q;
  logic [3:0]  count_q, count_d;
  logic [4:0]  busy_q, busy_d;
  logic [3:0]  retry_q, retry_d;
  logic        intr_q, intr_d, bo_pend_q, bo_pend_d, ack_pend_q, ack_pend_d;
  logic        res_valid_q;
  csma_pkg::result_t res_q, r;
  logic        fire, do_push;
  logic [47:0] head_addr_q;
  logic [3:0]  cap;
  logic        ev_rx;

  assign ev_ready_o  = !res_valid_q || res_ready_i;
  assign fire        = ev_valid_i && ev_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cap = (32'(cfg_i.queue_limit) > QUEUE_DEPTH) ? 4'(QUEUE_DEPTH) : cfg_i.queue_limit;
  assign ev_rx = (ev_i.kind == csma_pkg::EV_RXDATA) || (ev_i.kind == csma_pkg::EV_RXDUP) ||
                 (ev_i.kind == csma_pkg::EV_RXBCAST);

  function automatic logic [15:0] window_f(input csma_pkg::cfg_t c, input logic [4:0] busy);
    logic [5:0] be;
    logic [15:0] w;
    begin
      be = 6'(c.min_exponent) + 6'(busy);
      if (be > 6'(c.max_exponent)) be = 6'(c.max_exponent);
      if (c.backoff_mode == csma_pkg::BO_EXP) w = {1'b0, 15'((16'd1 << be[3:0]) - 16'd1)};
      else if (c.backoff_mode == csma_pkg::BO_LINEAR)
        w = {1'b1, 15'(16'(c.contention_window) + 16'(busy))};
      else w = {1'b1, 7'd0, c.contention_window};
      window_f = w;
    end
  endfunction

  // Next state and result
  always_comb begin
    logic [15:0] w;
    logic        pop, settle, backoff;
    state_d = state_q; head_d = head_q; count_d = count_q; busy_d = busy_q;
    retry_d = retry_q; intr_d = intr_q; bo_pend_d = bo_pend_q; ack_pend_d = ack_pend_q;
    r = '0; do_push = 1'b0; pop = 1'b0; settle = 1'b0; backoff = 1'b0; w = '0;
    if (ev_i.kind == csma_pkg::EV_BACKOFF) bo_pend_d = 1'b0;
    if (ev_i.kind == csma_pkg::EV_ACKTO) ack_pend_d = 1'b0;
    if (ev_i.kind == csma_pkg::EV_SEND) begin
      if (count_q < cap) begin
        do_push = 1'b1;
        count_d = count_q + 4'd1;
        if (state_q == csma_pkg::ST_IDLE) begin
          state_d = csma_pkg::ST_BACKOFF; busy_d = '0; backoff = 1'b1;
        end
      end else r.drop_cause = csma_pkg::DROP_FULL;
    end else begin
      case (state_q)
        csma_pkg::ST_IDLE: begin
          if (ev_i.kind == csma_pkg::EV_RXDATA || ev_i.kind == csma_pkg::EV_RXBCAST)
            r.deliver_up = 1'b1;
          if ((ev_i.kind == csma_pkg::EV_RXDATA || ev_i.kind == csma_pkg::EV_RXDUP)
              && cfg_i.use_acks) begin
            r.radio_mode = csma_pkg::RADIO_TX; state_d = csma_pkg::ST_WAITSIFS;
            r.timer_start = csma_pkg::TSTART_SIFS;
          end
        end
        csma_pkg::ST_BACKOFF, csma_pkg::ST_CCA: begin
          if (state_q == csma_pkg::ST_BACKOFF && ev_i.kind == csma_pkg::EV_BACKOFF) begin
            r.timer_start = csma_pkg::TSTART_CCA; state_d = csma_pkg::ST_CCA;
            r.radio_mode = csma_pkg::RADIO_RX;
          end else if (state_q == csma_pkg::ST_CCA && ev_i.kind == csma_pkg::EV_CCA) begin
            if (count_q == 4'd0) settle = 1'b1;
            else if (ev_i.channel_idle) begin
              state_d = csma_pkg::ST_TXFRAME; r.radio_mode = csma_pkg::RADIO_TX;
              r.transmit = csma_pkg::TX_FRAME;
            end else begin
              if (busy_q != 5'd31) busy_d = busy_q + 5'd1;
              if (busy_d > 5'(cfg_i.max_busy_backoffs)) begin
                pop = 1'b1; r.drop_cause = csma_pkg::DROP_BUSY; settle = 1'b1;
              end else begin
                state_d = csma_pkg::ST_BACKOFF; backoff = 1'b1;
              end
            end
          end else if (ev_rx) begin
            if (ev_i.kind != csma_pkg::EV_RXDUP) r.deliver_up = 1'b1;
            if (ev_i.kind != csma_pkg::EV_RXBCAST && cfg_i.use_acks) begin
              intr_d = 1'b1;
              if (state_q == csma_pkg::ST_CCA) r.timer_cancel = csma_pkg::TCANCEL_CCA;
              else begin
                r.timer_cancel = csma_pkg::TCANCEL_BO; bo_pend_d = 1'b0;
              end
              r.radio_mode = csma_pkg::RADIO_TX; state_d = csma_pkg::ST_WAITSIFS;
              r.timer_start = csma_pkg::TSTART_SIFS;
            end
          end
        end
        csma_pkg::ST_TXFRAME: begin
          if (ev_i.kind == csma_pkg::EV_TXDONE) begin
            r.radio_mode = csma_pkg::RADIO_RX;
            if (count_q != 4'd0 && cfg_i.use_acks && head_addr_q != csma_pkg::ADDR_BCAST) begin
              state_d = csma_pkg::ST_WAITACK; r.timer_start = csma_pkg::TSTART_ACK;
              ack_pend_d = 1'b1;
            end else begin
              pop = 1'b1; settle = 1'b1;
            end
          end
        end
        csma_pkg::ST_WAITACK: begin
          if (ev_i.kind == csma_pkg::EV_RXACK) begin
            if (count_q != 4'd0 && ev_i.ack_source == head_addr_q) begin
              if (ack_pend_q) begin
                r.timer_cancel = csma_pkg::TCANCEL_ACK; ack_pend_d = 1'b0;
              end
              pop = 1'b1; settle = 1'b1;
            end
          end else if (ev_i.kind == csma_pkg::EV_ACKTO) begin
            if (retry_q < cfg_i.max_retries) retry_d = retry_q + 4'd1;
            else begin
              pop = 1'b1; r.drop_cause = csma_pkg::DROP_RETRY;
            end
            settle = 1'b1;
          end else if (ev_i.kind == csma_pkg::EV_RXDATA || ev_i.kind == csma_pkg::EV_RXBCAST)
            r.deliver_up = 1'b1;
        end
        csma_pkg::ST_WAITSIFS: begin
          if (ev_i.kind == csma_pkg::EV_SIFS) begin
            state_d = csma_pkg::ST_TXACK; r.transmit = csma_pkg::TX_ACK;
          end else if (ev_i.kind == csma_pkg::EV_BACKOFF) backoff = 1'b1;
          else if (ev_i.kind == csma_pkg::EV_RXDATA || ev_i.kind == csma_pkg::EV_RXBCAST)
            r.deliver_up = 1'b1;
        end
        csma_pkg::ST_TXACK: begin
          if (ev_i.kind == csma_pkg::EV_TXDONE) begin
            r.radio_mode = csma_pkg::RADIO_RX; settle = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Drop the head frame
    if (pop) begin
      if (count_q != 4'd0) begin
        head_d = (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
        count_d = count_q - 4'd1;
      end
      retry_d = '0;
    end
    // Resume backoff or go idle
    if (settle) begin
      if (count_d != 4'd0) begin
        if (intr_d) intr_d = 1'b0;
        else busy_d = '0;
        if (!bo_pend_d) backoff = 1'b1;
        state_d = csma_pkg::ST_BACKOFF;
      end else state_d = csma_pkg::ST_IDLE;
    end
    if (backoff) begin
      w = window_f(cfg_i, busy_d);
      r.timer_start = csma_pkg::TSTART_BO; bo_pend_d = 1'b1;
      r.window_low = w[15]; r.window_high = w[14:0];
    end
    r.mac_state = state_d;
    r.queue_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csma_pkg::ST_IDLE; head_q <= '0; tail_q <= '0; count_q <= '0;
      busy_q <= '0; retry_q <= '0; intr_q <= 1'b0; bo_pend_q <= 1'b0;
      ack_pend_q <= 1'b0; res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d; head_q <= head_d; count_q <= count_d; busy_q <= busy_d;
        retry_q <= retry_d; intr_q <= intr_d; bo_pend_q <= bo_pend_d;
        ack_pend_q <= ack_pend_d;
        if (do_push) tail_q <= (32'(tail_q) == QUEUE_DEPTH - 1) ? '0 : tail_q + 1'b1;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // Hold the result, write the destination store and register the head entry;
  // a frame pushed into an empty queue becomes the head directly
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= r;
      if (do_push) store_q[tail_q] <= ev_i.dest_address;
      if (do_push && count_q == 4'd0) head_addr_q <= ev_i.dest_address;
      else head_addr_q <= store_q[head_d];
    end
  end

endmodule

/* design/csma_ca_mac_controller.sv */
// ---------------------------------------------------------------------------
// CSMA-CA MAC controller top level
// Event front end, event queue and MAC engine.
// ---------------------------------------------------------------------------
// Usage: events enter on the in_valid_i/in_ready_o channel (kind, addresses,
// channel_idle); each event yields exactly one result on out_valid_o/
// out_ready_i carrying radio, timer, transmit, deliver and drop commands,
// the backoff window, the new state and the queue count.
// An event transfers into a two-entry queue; the engine pops it from the
// queue and registers its result, which is then offered on out_valid_o.
// The engine applies one event per cycle while each result is taken, so
// one event per cycle is sustained when out_ready_i stays high.
// When the receiver stalls, the engine holds its result, the queue fills and
// in_ready_o falls once both queue entries are taken.
// Reset clears the state machine, queue pointers and counters and loads
// register defaults. The user writes registers through cfg_we_i/cfg_index_i/
// cfg_data_i only while no event is in flight; the block does not check it.
// ---------------------------------------------------------------------------
`include "csma_ca_mac_controller_macros.svh"

module csma_ca_mac_controller #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  logic [47:0] dest_address_i,
  input  logic [47:0] ack_source_i,
  input  logic        channel_idle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  radio_mode_o,
  output logic [2:0]  timer_start_o,
  output logic [1:0]  timer_cancel_o,
  output logic [1:0]  transmit_o,
  output logic        deliver_up_o,
  output logic [1:0]  drop_cause_o,
  output logic        window_low_o,
  output logic [14:0] window_high_o,
  output logic [2:0]  mac_state_o,
  output logic [3:0]  queue_count_o
);

  csma_pkg::cfg_t    cfg_q;
  csma_pkg::event_t  ev_in, ev_out;
  csma_pkg::result_t res;
  logic fifo_full, ev_valid, ev_ready;

  // Load configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{use_acks: 1'b1, queue_limit: 4'd8, max_busy_backoffs: 4'd4,
                 max_retries: 4'd3, backoff_mode: 2'd2, min_exponent: 4'd3,
                 max_exponent: 4'd5, contention_window: 8'd8};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        csma_pkg::CFG_USE_ACKS:  cfg_q.use_acks <= cfg_data_i[0];
        csma_pkg::CFG_QLIMIT:    cfg_q.queue_limit <= cfg_data_i[3:0];
        csma_pkg::CFG_MAX_BUSY:  cfg_q.max_busy_backoffs <= cfg_data_i[3:0];
        csma_pkg::CFG_MAX_RETRY: cfg_q.max_retries <= cfg_data_i[3:0];
        csma_pkg::CFG_BO_MODE:   cfg_q.backoff_mode <= cfg_data_i[1:0];
        csma_pkg::CFG_MIN_EXP:   cfg_q.min_exponent <= cfg_data_i[3:0];
        csma_pkg::CFG_MAX_EXP:   cfg_q.max_exponent <= cfg_data_i[3:0];
        csma_pkg::CFG_CW:        cfg_q.contention_window <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !fifo_full;
  assign ev_in = '{kind: kind_i, dest_address: dest_address_i,
                   ack_source: ack_source_i, channel_idle: channel_idle_i};

  csma_evt_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && in_ready_o), .push_data_i(ev_in), .full_o(fifo_full),
    .pop_valid_o(ev_valid), .pop_i(ev_valid && ev_ready), .pop_data_o(ev_out)
  );

  csma_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .ev_valid_i(ev_valid), .ev_i(ev_out), .ev_ready_o(ev_ready),
    .res_valid_o(out_valid_o), .res_o(res), .res_ready_i(out_ready_i)
  );

  assign radio_mode_o   = res.radio_mode;
  assign timer_start_o  = res.timer_start;
  assign timer_cancel_o = res.timer_cancel;
  assign transmit_o     = res.transmit;
  assign deliver_up_o   = res.deliver_up;
  assign drop_cause_o   = res.drop_cause;
  assign window_low_o   = res.window_low;
  assign window_high_o  = res.window_high;
  assign mac_state_o    = res.mac_state;
  assign queue_count_o  = res.queue_count;

  `CSMA_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 out_valid_o && $stable(res))
  `CSMA_ASSERT_IMPL(a_window_only_bo, clk_i, rst_ni, out_valid_o && timer_start_o != csma_pkg::TSTART_BO, window_low_o == 1'b0 && window_high_o == 15'd0)
  `CSMA_ASSERT_IMPL(a_idle_empty, clk_i, rst_ni, out_valid_o && mac_state_o == csma_pkg::ST_IDLE, queue_count_o == 4'd0)

endmodule

/* tb/sv/tb_csma_ca_mac_controller.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CSMA-CA MAC controller testbench
// Drives MAC events through the valid/ready input channel, predicts each
// result with a cycle-free model of the controller and compares every
// result field. Runs directed cases, then random well-formed transmit
// sequences mixed with noise events under several register settings.
// ---------------------------------------------------------------------------
module tb_csma_ca_mac_controller;

  localparam int BufDepth = 4096;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  kind_i;
  logic [47:0] dest_address_i;
  logic [47:0] ack_source_i;
  logic        channel_idle_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  radio_mode_o;
  logic [2:0]  timer_start_o;
  logic [1:0]  timer_cancel_o;
  logic [1:0]  transmit_o;
  logic        deliver_up_o;
  logic [1:0]  drop_cause_o;
  logic        window_low_o;
  logic [14:0] window_high_o;
  logic [2:0]  mac_state_o;
  logic [3:0]  queue_count_o;

  csma_ca_mac_controller u_dut (.*);

  // Predictor state
  csma_pkg::cfg_t       cfg;
  csma_pkg::mac_state_e phase;
  logic [47:0] dest_store [8];
  logic [2:0]  head_ptr, tail_ptr;
  logic [3:0]  frame_cnt;
  logic [4:0]  busy_cnt;
  logic [3:0]  retry_cnt;
  logic        interrupted, bo_pending, ackw_pending;
  csma_pkg::result_t res;

  // Pending events and expected results, each with its own write and read index
  csma_pkg::event_t  pend_mem [BufDepth];
  csma_pkg::result_t exp_mem [BufDepth];
  int      pend_wr, pend_rd;
  int      exp_wr, exp_rd;
  int      mismatches;
  int      results_seen;
  int      sent_count;
  bit      drive_idle_free;
  bit      monitor_idle_free;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void start_backoff_window();
    int be;
    res.timer_start = csma_pkg::TSTART_BO;
    bo_pending = 1'b1;
    if (cfg.backoff_mode == csma_pkg::BO_EXP) begin
      be = cfg.min_exponent + busy_cnt;
      if (be > cfg.max_exponent) be = cfg.max_exponent;
      res.window_low  = 1'b0;
      res.window_high = 15'((1 << be) - 1);
    end else if (cfg.backoff_mode == csma_pkg::BO_LINEAR) begin
      res.window_low  = 1'b1;
      res.window_high = 15'(cfg.contention_window + busy_cnt);
    end else begin
      res.window_low  = 1'b1;
      res.window_high = 15'(cfg.contention_window);
    end
  endfunction

  function automatic void pop_frame();
    if (frame_cnt != 0) begin
      head_ptr  = head_ptr + 3'd1;
      frame_cnt = frame_cnt - 4'd1;
    end
    retry_cnt = '0;
  endfunction

  function automatic void settle_after_frame();
    if (frame_cnt != 0) begin
      if (interrupted) interrupted = 1'b0;
      else busy_cnt = '0;
      if (!bo_pending) start_backoff_window();
      phase = csma_pkg::ST_BACKOFF;
    end else begin
      phase = csma_pkg::ST_IDLE;
    end
  endfunction

  function automatic void enter_ack_reply(bit from_cca);
    interrupted = 1'b1;
    if (from_cca) res.timer_cancel = csma_pkg::TCANCEL_CCA;
    else begin
      res.timer_cancel = csma_pkg::TCANCEL_BO;
      bo_pending = 1'b0;
    end
    res.radio_mode  = csma_pkg::RADIO_TX;
    phase           = csma_pkg::ST_WAITSIFS;
    res.timer_start = csma_pkg::TSTART_SIFS;
  endfunction

  function automatic void receive_in_access(logic [3:0] k);
    if (k != csma_pkg::EV_RXDUP) res.deliver_up = 1'b1;
    if (k != csma_pkg::EV_RXBCAST && cfg.use_acks) enter_ack_reply(phase == csma_pkg::ST_CCA);
  endfunction

  function automatic void reset_model();
    cfg = '{use_acks: 1'b1, queue_limit: 4'd8, max_busy_backoffs: 4'd4,
            max_retries: 4'd3, backoff_mode: 2'd2, min_exponent: 4'd3,
            max_exponent: 4'd5, contention_window: 8'd8};
    phase = csma_pkg::ST_IDLE;
    head_ptr = '0; tail_ptr = '0; frame_cnt = '0;
    busy_cnt = '0; retry_cnt = '0;
    interrupted = 1'b0; bo_pending = 1'b0; ackw_pending = 1'b0;
    foreach (dest_store[i]) dest_store[i] = '0;
  endfunction

  // Compute the result of one MAC event and advance the model
  function automatic csma_pkg::result_t mac_event_result(csma_pkg::event_t ev);
    logic [47:0] head;
    int cap;
    head = dest_store[head_ptr];
    res = '0;
    if (ev.kind == csma_pkg::EV_BACKOFF) bo_pending = 1'b0;
    if (ev.kind == csma_pkg::EV_ACKTO) ackw_pending = 1'b0;
    if (ev.kind == csma_pkg::EV_SEND) begin
      cap = (cfg.queue_limit > 8) ? 8 : cfg.queue_limit;
      if (frame_cnt < cap) begin
        dest_store[tail_ptr] = ev.dest_address;
        tail_ptr  = tail_ptr + 3'd1;
        frame_cnt = frame_cnt + 4'd1;
        if (phase == csma_pkg::ST_IDLE) begin
          phase = csma_pkg::ST_BACKOFF;
          busy_cnt = '0;
          start_backoff_window();
        end
      end else res.drop_cause = csma_pkg::DROP_FULL;
    end else begin
      case (phase)
        csma_pkg::ST_IDLE: begin
          if (ev.kind == csma_pkg::EV_RXDATA || ev.kind == csma_pkg::EV_RXBCAST)
            res.deliver_up = 1'b1;
          if ((ev.kind == csma_pkg::EV_RXDATA || ev.kind == csma_pkg::EV_RXDUP)
              && cfg.use_acks) begin
            res.radio_mode = csma_pkg::RADIO_TX; phase = csma_pkg::ST_WAITSIFS;
            res.timer_start = csma_pkg::TSTART_SIFS;
          end
        end
        csma_pkg::ST_BACKOFF: begin
          if (ev.kind == csma_pkg::EV_BACKOFF) begin
            res.timer_start = csma_pkg::TSTART_CCA; phase = csma_pkg::ST_CCA;
            res.radio_mode = csma_pkg::RADIO_RX;
          end else if (ev.kind >= csma_pkg::EV_RXDATA && ev.kind <= csma_pkg::EV_RXBCAST) begin
            receive_in_access(ev.kind);
          end
        end
        csma_pkg::ST_CCA: begin
          if (ev.kind == csma_pkg::EV_CCA) begin
            if (frame_cnt == 0) settle_after_frame();
            else if (ev.channel_idle) begin
              phase = csma_pkg::ST_TXFRAME; res.radio_mode = csma_pkg::RADIO_TX;
              res.transmit = csma_pkg::TX_FRAME;
            end else begin
              if (busy_cnt < 31) busy_cnt = busy_cnt + 5'd1;
              if (busy_cnt > cfg.max_busy_backoffs) begin
                pop_frame();
                res.drop_cause = csma_pkg::DROP_BUSY;
                settle_after_frame();
              end else begin
                phase = csma_pkg::ST_BACKOFF;
                start_backoff_window();
              end
            end
          end else if (ev.kind >= csma_pkg::EV_RXDATA && ev.kind <= csma_pkg::EV_RXBCAST) begin
            receive_in_access(ev.kind);
          end
        end
        csma_pkg::ST_TXFRAME: begin
          if (ev.kind == csma_pkg::EV_TXDONE) begin
            res.radio_mode = csma_pkg::RADIO_RX;
            if (frame_cnt != 0 && cfg.use_acks && head != csma_pkg::ADDR_BCAST) begin
              phase = csma_pkg::ST_WAITACK; res.timer_start = csma_pkg::TSTART_ACK;
              ackw_pending = 1'b1;
            end else begin
              pop_frame();
              settle_after_frame();
            end
          end
        end
        csma_pkg::ST_WAITACK: begin
          if (ev.kind == csma_pkg::EV_RXACK) begin
            if (frame_cnt != 0 && ev.ack_source == head) begin
              if (ackw_pending) begin
                res.timer_cancel = csma_pkg::TCANCEL_ACK; ackw_pending = 1'b0;
              end
              pop_frame();
              settle_after_frame();
            end
          end else if (ev.kind == csma_pkg::EV_ACKTO) begin
            if (retry_cnt < cfg.max_retries) retry_cnt = retry_cnt + 4'd1;
            else begin
              pop_frame();
              res.drop_cause = csma_pkg::DROP_RETRY;
            end
            settle_after_frame();
          end else if (ev.kind == csma_pkg::EV_RXDATA || ev.kind == csma_pkg::EV_RXBCAST) begin
            res.deliver_up = 1'b1;
          end
        end
        csma_pkg::ST_WAITSIFS: begin
          if (ev.kind == csma_pkg::EV_SIFS) begin
            phase = csma_pkg::ST_TXACK; res.transmit = csma_pkg::TX_ACK;
          end else if (ev.kind == csma_pkg::EV_BACKOFF) start_backoff_window();
          else if (ev.kind == csma_pkg::EV_RXDATA || ev.kind == csma_pkg::EV_RXBCAST)
            res.deliver_up = 1'b1;
        end
        csma_pkg::ST_TXACK: begin
          if (ev.kind == csma_pkg::EV_TXDONE) begin
            res.radio_mode = csma_pkg::RADIO_RX;
            settle_after_frame();
          end
        end
        default: ;
      endcase
    end
    res.mac_state   = phase;
    res.queue_count = frame_cnt;
    return res;
  endfunction

  // Driver: present queued events, hold until transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) sent_count <= sent_count + 1;
      if (!in_valid_i || in_ready_o) begin
        if (pend_rd != pend_wr && (drive_idle_free || $urandom_range(99) >= 29)) begin
          csma_pkg::event_t ev;
          ev = pend_mem[pend_rd];
          pend_rd         <= pend_rd + 1;
          exp_mem[exp_wr] <= mac_event_result(ev);
          exp_wr          <= exp_wr + 1;
          kind_i          <= ev.kind;
          dest_address_i  <= ev.dest_address;
          ack_source_i    <= ev.ack_source;
          channel_idle_i  <= ev.channel_idle;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: randomize ready, compare each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        csma_pkg::result_t got, want;
        got = '{radio_mode_o, timer_start_o, timer_cancel_o, transmit_o, deliver_up_o,
                drop_cause_o, window_low_o, window_high_o, mac_state_o, queue_count_o};
        results_seen <= results_seen + 1;
        if (exp_rd == exp_wr) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", got);
        end else begin
          want = exp_mem[exp_rd];
          exp_rd <= exp_rd + 1;
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ready_i <= monitor_idle_free || ($urandom_range(99) >= 29);
    end
  end

  task automatic push_event(logic [3:0] k, logic [47:0] dst = '0,
                            logic [47:0] asrc = '0, logic idle_ch = 1'b1);
    csma_pkg::event_t ev;
    ev.kind = k; ev.dest_address = dst; ev.ack_source = asrc; ev.channel_idle = idle_ch;
    pend_mem[pend_wr] = ev;
    pend_wr = pend_wr + 1;
  endtask

  task automatic wait_drained();
    while (pend_rd != pend_wr || in_valid_i || exp_rd != exp_wr)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write one register while the block is idle, mirror it in the model
  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      csma_pkg::CFG_USE_ACKS:  cfg.use_acks = val[0];
      csma_pkg::CFG_QLIMIT:    cfg.queue_limit = val[3:0];
      csma_pkg::CFG_MAX_BUSY:  cfg.max_busy_backoffs = val[3:0];
      csma_pkg::CFG_MAX_RETRY: cfg.max_retries = val[3:0];
      csma_pkg::CFG_BO_MODE:   cfg.backoff_mode = val[1:0];
      csma_pkg::CFG_MIN_EXP:   cfg.min_exponent = val[3:0];
      csma_pkg::CFG_MAX_EXP:   cfg.max_exponent = val[3:0];
      csma_pkg::CFG_CW:        cfg.contention_window = val;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  // Queue one transmit attempt: backoff, CCA, tx done, then ack or timeout
  task automatic push_attempt(logic [47:0] dst);
    int r;
    push_event(csma_pkg::EV_BACKOFF);
    if ($urandom_range(9) == 0) push_event(4'($urandom_range(6, 8)));
    push_event(csma_pkg::EV_CCA, '0, '0, $urandom_range(3) != 0);
    push_event(csma_pkg::EV_TXDONE);
    r = $urandom_range(9);
    if (r < 5) push_event(csma_pkg::EV_RXACK, '0, dst);
    else if (r < 8) push_event(csma_pkg::EV_ACKTO);
    else push_event(csma_pkg::EV_RXACK, '0, rand_addr());
    if ($urandom_range(7) == 0) begin
      push_event(csma_pkg::EV_SIFS);
      push_event(csma_pkg::EV_TXDONE);
    end
  endtask

  task automatic random_phase(int n);
    int base;
    logic [47:0] dst;
    base = pend_wr;
    while (pend_wr - base < n) begin
      if ($urandom_range(99) < 75) begin
        dst = ($urandom_range(7) == 0) ? csma_pkg::ADDR_BCAST : rand_addr();
        push_event(csma_pkg::EV_SEND, dst);
        repeat ($urandom_range(1, 3)) push_attempt(dst);
      end else begin
        push_event(4'($urandom_range(15)), rand_addr(), rand_addr(), 1'($urandom()));
      end
      if ($urandom_range(3) == 0) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    kind_i = '0; dest_address_i = '0; ack_source_i = '0; channel_idle_i = 1'b0;
    mismatches = 0; results_seen = 0; sent_count = 0;
    pend_wr = 0; pend_rd = 0; exp_wr = 0; exp_rd = 0;
    drive_idle_free = 1'b0; monitor_idle_free = 1'b0;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every event kind, ack filter, broadcast, full queue
    push_event(csma_pkg::EV_SEND, '0);
    push_event(csma_pkg::EV_BACKOFF);
    push_event(csma_pkg::EV_CCA, '0, '0, 1'b0);
    push_event(csma_pkg::EV_BACKOFF);
    push_event(csma_pkg::EV_RXDATA);
    push_event(csma_pkg::EV_SIFS);
    push_event(csma_pkg::EV_TXDONE);
    push_event(csma_pkg::EV_BACKOFF);
    push_event(csma_pkg::EV_CCA, '0, '0, 1'b1);
    push_event(csma_pkg::EV_TXDONE);
    push_event(csma_pkg::EV_RXACK, '0, csma_pkg::ADDR_BCAST);
    push_event(csma_pkg::EV_RXBCAST);
    push_event(csma_pkg::EV_ACKTO);
    push_event(csma_pkg::EV_RXACK, '0, '0);
    push_event(csma_pkg::EV_SEND, csma_pkg::ADDR_BCAST);
    push_event(csma_pkg::EV_BACKOFF);
    push_event(csma_pkg::EV_CCA, '0, '0, 1'b1);
    push_event(csma_pkg::EV_TXDONE);
    push_event(4'd15, csma_pkg::ADDR_BCAST, csma_pkg::ADDR_BCAST, 1'b1);
    push_event(csma_pkg::EV_RXDUP);
    push_event(csma_pkg::EV_SIFS);
    push_event(csma_pkg::EV_TXDONE);
    repeat (9) push_event(csma_pkg::EV_SEND, 48'h5555_AAAA_5555);
    wait_drained();

    // Sender holds off until every result is back
    wait_drained();

    // Phase settings: defaults, then extremes
    drive_idle_free = 1'b1; monitor_idle_free = 1'b1;
    random_phase(80);
    wait_drained();
    drive_idle_free = 1'b0; monitor_idle_free = 1'b0;

    write_reg(csma_pkg::CFG_USE_ACKS, 8'd0);
    write_reg(csma_pkg::CFG_QLIMIT, 8'd1);
    write_reg(csma_pkg::CFG_MAX_BUSY, 8'd0);
    write_reg(csma_pkg::CFG_MAX_RETRY, 8'd0);
    write_reg(csma_pkg::CFG_BO_MODE, 8'd0);
    write_reg(csma_pkg::CFG_MIN_EXP, 8'd0);
    write_reg(csma_pkg::CFG_MAX_EXP, 8'd0);
    write_reg(csma_pkg::CFG_CW, 8'd0);
    random_phase(110);
    wait_drained();

    write_reg(csma_pkg::CFG_USE_ACKS, 8'd1);
    write_reg(csma_pkg::CFG_QLIMIT, 8'd15);
    write_reg(csma_pkg::CFG_MAX_BUSY, 8'd15);
    write_reg(csma_pkg::CFG_MAX_RETRY, 8'd15);
    write_reg(csma_pkg::CFG_BO_MODE, 8'd1);
    write_reg(csma_pkg::CFG_CW, 8'd255);
    random_phase(110);
    wait_drained();

    write_reg(csma_pkg::CFG_BO_MODE, 8'd2);
    write_reg(csma_pkg::CFG_MIN_EXP, 8'd15);
    write_reg(csma_pkg::CFG_MAX_EXP, 8'd15);
    write_reg(csma_pkg::CFG_MAX_BUSY, 8'd3);
    random_phase(110);
    wait_drained();

    write_reg(csma_pkg::CFG_BO_MODE, 8'd3);
    write_reg(csma_pkg::CFG_QLIMIT, 8'd3);
    write_reg(csma_pkg::CFG_MAX_RETRY, 8'd1);
    write_reg(csma_pkg::CFG_CW, 8'd1);
    random_phase(110);
    wait_drained();

    write_reg(csma_pkg::CFG_BO_MODE, 8'd2);
    write_reg(csma_pkg::CFG_MIN_EXP, 8'd2);
    write_reg(csma_pkg::CFG_MAX_EXP, 8'd6);
    write_reg(csma_pkg::CFG_MAX_BUSY, 8'd7);
    random_phase(110);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d events and %0d results over six register settings,",
             sent_count, results_seen);
    $display("including busy drops, retry exhaustion, ack replies and queue overflow.");
    if (mismatches == 0 && exp_rd == exp_wr)
      $display("tb_csma_ca_mac_controller: clean");
    else
      $display("tb_csma_ca_mac_controller: errors");
    $finish;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("tb_csma_ca_mac_controller: errors");
    $finish;
  end

endmodule
